// File: rtl/bcr_pkg.sv
// ----------------------------------------------------------------------------
// bcr_pkg
// Shared widths, codes, state types and helpers of the stereo bitcrusher.
// ----------------------------------------------------------------------------
package bcr_pkg;

  localparam int unsigned MAX_BLOCK_DEF = 4096;

  localparam int unsigned FC_W    = 13;  // frame count
  localparam int unsigned MOD_W   = 26;  // modulation offsets
  localparam int unsigned SMP_W   = 24;  // audio samples
  localparam int unsigned BASE_W  = 25;  // Q1.24 registers
  localparam int unsigned GAIN_W  = 23;  // Q7.16 gains
  localparam int unsigned LVL_W   = 41;  // levels, 0 .. 2^40
  localparam int unsigned SLP_W   = 42;  // signed slopes
  localparam int unsigned DIV_W   = 48;  // divider dividend magnitude
  localparam int unsigned DSR_W   = 41;  // divider divisor
  localparam int unsigned DIV_STEPS = 2; // quotient bits per cycle
  localparam int unsigned IN_W    = 120;
  localparam int unsigned OUT_W   = 48;
  localparam int unsigned CFG_A_W = 2;

  localparam logic [LVL_W-1:0]  ONE40 = LVL_W'(1) << 40;
  localparam logic [BASE_W-1:0] ONE24 = BASE_W'(1) << 24;

  typedef enum logic [CFG_A_W-1:0] {
    REG_DRYWET = 2'd0,
    REG_CRUSH  = 2'd1,
    REG_GAIN   = 2'd2,
    REG_RECIP  = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_BLOCK = 1'b0,
    OP_FRAME = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    T_IDLE, T_CRV1, T_CRV2, T_TGT, T_SLOPE, T_FRAME, T_OUT
  } top_state_e;

  typedef enum logic [2:0] {
    L_IDLE, L_MUL, L_LOAD, L_DIV, L_WET, L_DIFF, L_PROD, L_SUM
  } lane_state_e;

  typedef struct packed {
    logic start;
    logic frame;
    logic step_zero;
  } lane_ctrl_t;

  typedef struct packed {
    logic                     done;
    logic signed [SLP_W-1:0]  quo;
    logic signed [SMP_W-1:0]  sample;
  } lane_res_t;

  // Advance a level by its slope and saturate to [0, 2^40].
  function automatic logic [LVL_W-1:0] lvl_step(input logic [LVL_W-1:0] lvl,
                                                input logic signed [SLP_W-1:0] slp);
    logic signed [LVL_W+1:0] s;
    s = $signed({2'b00, lvl}) + $signed({slp[SLP_W-1], slp});
    if (s < 0) begin
      lvl_step = '0;
    end else if (s > $signed({2'b00, ONE40})) begin
      lvl_step = ONE40;
    end else begin
      lvl_step = s[LVL_W-1:0];
    end
  endfunction

endpackage

// File: rtl/bitcrusher_with_param_ramp.sv
// ----------------------------------------------------------------------------
// bitcrusher_with_param_ramp
// Stereo bitcrusher with linear dry/wet and quantizer-step ramps per block.
// ----------------------------------------------------------------------------
// Frame path: a frame goes through the lane states multiply, load, divide,
//   wet, difference, product and sum, then into the output register; with
//   a zero step the divide is skipped. One transaction at a time: a frame
//   ends once its result is loaded, so a stalled output holds the input; a
//   block start runs the curve and target states, then for a nonzero count the slope divide.
// Reset: asynchronous, active low; levels and slopes clear to zero, the
//   configuration registers return to their default values.
module bitcrusher_with_param_ramp #(
  parameter int unsigned MAX_BLOCK = bcr_pkg::MAX_BLOCK_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // frame_count, drywet_mod, crush_mod, mono_in, left_in, right_in, zero pad
  input  logic [bcr_pkg::IN_W-1:0]      s_axis_tdata,
  // opcode
  input  logic                          s_axis_tuser,
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // left_out, right_out
  output logic [bcr_pkg::OUT_W-1:0]     m_axis_tdata,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bcr_pkg::CFG_A_W-1:0]   cfg_addr_i,
  input  logic [bcr_pkg::BASE_W-1:0]    cfg_data_i
);

  localparam int unsigned FC_MAX = (1 << bcr_pkg::FC_W) - 1;
  localparam int unsigned NCAP   = (MAX_BLOCK < FC_MAX) ? MAX_BLOCK : FC_MAX;

  bcr_pkg::top_state_e state_q, state_d;

  // configuration
  logic [bcr_pkg::BASE_W-1:0] drywet_q, crush_q;
  logic [bcr_pkg::GAIN_W-1:0] gain_q, recip_q;

  // captured transaction fields
  logic [bcr_pkg::FC_W-1:0]         fc_q;
  logic signed [bcr_pkg::MOD_W-1:0] mdw_q, mcr_q;
  logic                             mono_q;
  logic signed [bcr_pkg::SMP_W-1:0] left_q, right_q;

  // ramp state
  logic [bcr_pkg::LVL_W-1:0]        mix_lvl_q, qstep_q;
  logic signed [bcr_pkg::SLP_W-1:0] mix_slp_q, qslp_q;

  // crush curve pipeline
  logic [bcr_pkg::BASE_W-1:0] dw_q;
  logic [28:0]                u2_q;
  logic [bcr_pkg::LVL_W-1:0]  steptgt_q;

  // output register
  logic                             ov_q;
  logic signed [bcr_pkg::SMP_W-1:0] lout_q, rout_q;

  logic                           acc_in, frame_done, load_out;
  logic signed [26:0]             dw_sum, cb_sum;
  logic [bcr_pkg::BASE_W-1:0]     dw_c, cb_c, u_c;
  logic [49:0]                    uu;
  logic [57:0]                    u2sq;
  logic [bcr_pkg::LVL_W-1:0]      u4, mix_tgt;
  logic [bcr_pkg::FC_W-1:0]       n_cap;

  bcr_pkg::lane_ctrl_t              ctrl;
  bcr_pkg::lane_res_t               res_l, res_r;
  logic signed [bcr_pkg::SLP_W-1:0] dvd_l, dvd_r;
  logic [bcr_pkg::DSR_W-1:0]        dsr;
  logic signed [bcr_pkg::SMP_W-1:0] right_sel;

  assign acc_in        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == bcr_pkg::T_IDLE);
  assign cfg_ready_o   = 1'b1;

  // Block-start math: clamp the targets, then shape the crush curve.
  always_comb begin
    dw_sum = $signed({2'b00, drywet_q}) + $signed({mdw_q[bcr_pkg::MOD_W-1], mdw_q});
    cb_sum = $signed({2'b00, crush_q})  + $signed({mcr_q[bcr_pkg::MOD_W-1], mcr_q});
    if (dw_sum < 0) dw_c = '0;
    else if (dw_sum > $signed({2'b00, bcr_pkg::ONE24})) dw_c = bcr_pkg::ONE24;
    else dw_c = dw_sum[bcr_pkg::BASE_W-1:0];
    if (cb_sum < 0) cb_c = '0;
    else if (cb_sum > $signed({2'b00, bcr_pkg::ONE24})) cb_c = bcr_pkg::ONE24;
    else cb_c = cb_sum[bcr_pkg::BASE_W-1:0];
    u_c     = bcr_pkg::ONE24 - cb_c;
    uu      = 50'(u_c) * 50'(u_c);
    u2sq    = 58'(u2_q) * 58'(u2_q);
    u4      = u2sq[56:16];
    mix_tgt = {dw_q, 16'b0};
    n_cap   = (fc_q > bcr_pkg::FC_W'(NCAP)) ? bcr_pkg::FC_W'(NCAP) : fc_q;
  end

  // Lanes: left and right share the step; in a block start the left lane
  // divides the mix delta and the right lane the step delta.
  assign frame_done = res_l.done && res_r.done;
  assign right_sel  = mono_q ? left_q : right_q;
  assign dvd_l      = $signed({1'b0, mix_tgt})   - $signed({1'b0, mix_lvl_q});
  assign dvd_r      = $signed({1'b0, steptgt_q}) - $signed({1'b0, qstep_q});
  assign dsr        = (state_q == bcr_pkg::T_TGT || state_q == bcr_pkg::T_SLOPE) ?
                      bcr_pkg::DSR_W'(n_cap) : qstep_q;

  always_comb begin
    ctrl.start     = (acc_in && s_axis_tuser == bcr_pkg::OP_FRAME) ||
                     (state_q == bcr_pkg::T_TGT && n_cap != '0);
    ctrl.frame     = (state_q == bcr_pkg::T_IDLE);
    ctrl.step_zero = (qstep_q == '0);
  end

  bcr_lane u_lane_l (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .sample_i   (left_q),
    .gain_i     (gain_q),
    .recip_i    (recip_q),
    .mix_i      (mix_lvl_q[40:16]),
    .dividend_i (dvd_l),
    .divisor_i  (dsr),
    .res_o      (res_l)
  );

  bcr_lane u_lane_r (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .sample_i   (right_sel),
    .gain_i     (gain_q),
    .recip_i    (recip_q),
    .mix_i      (mix_lvl_q[40:16]),
    .dividend_i (dvd_r),
    .divisor_i  (dsr),
    .res_o      (res_r)
  );

  // Merge: load the output register once it is free and the lanes finished.
  assign load_out = ((state_q == bcr_pkg::T_FRAME && frame_done) ||
                     state_q == bcr_pkg::T_OUT) && (!ov_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bcr_pkg::T_IDLE: begin
        if (acc_in) begin
          state_d = (s_axis_tuser == bcr_pkg::OP_FRAME) ? bcr_pkg::T_FRAME : bcr_pkg::T_CRV1;
        end
      end
      bcr_pkg::T_CRV1:  state_d = bcr_pkg::T_CRV2;
      bcr_pkg::T_CRV2:  state_d = bcr_pkg::T_TGT;
      bcr_pkg::T_TGT:   state_d = (n_cap == '0) ? bcr_pkg::T_IDLE : bcr_pkg::T_SLOPE;
      bcr_pkg::T_SLOPE: if (frame_done) state_d = bcr_pkg::T_IDLE;
      bcr_pkg::T_FRAME: begin
        if (frame_done) state_d = load_out ? bcr_pkg::T_IDLE : bcr_pkg::T_OUT;
      end
      bcr_pkg::T_OUT:   if (load_out) state_d = bcr_pkg::T_IDLE;
      default:          state_d = bcr_pkg::T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bcr_pkg::T_IDLE;
      ov_q      <= 1'b0;
      drywet_q  <= bcr_pkg::ONE24;
      crush_q   <= bcr_pkg::ONE24;
      gain_q    <= bcr_pkg::GAIN_W'(65536);
      recip_q   <= bcr_pkg::GAIN_W'(65536);
      mix_lvl_q <= '0;
      mix_slp_q <= '0;
      qstep_q   <= '0;
      qslp_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (bcr_pkg::cfg_reg_e'(cfg_addr_i))
          bcr_pkg::REG_DRYWET: drywet_q <= cfg_data_i;
          bcr_pkg::REG_CRUSH:  crush_q  <= cfg_data_i;
          bcr_pkg::REG_GAIN:   gain_q   <= cfg_data_i[bcr_pkg::GAIN_W-1:0];
          bcr_pkg::REG_RECIP:  recip_q  <= cfg_data_i[bcr_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end
      // Zero count: snap both levels to their targets.
      if (state_q == bcr_pkg::T_TGT && n_cap == '0) begin
        mix_lvl_q <= mix_tgt;
        mix_slp_q <= '0;
        qstep_q   <= steptgt_q;
        qslp_q    <= '0;
      end
      if (state_q == bcr_pkg::T_SLOPE && frame_done) begin
        mix_slp_q <= res_l.quo;
        qslp_q    <= res_r.quo;
      end
      // Advance the ramps after each frame, using the old levels for its output.
      if (load_out) begin
        mix_lvl_q <= bcr_pkg::lvl_step(mix_lvl_q, mix_slp_q);
        qstep_q   <= bcr_pkg::lvl_step(qstep_q, qslp_q);
      end
      if (load_out) ov_q <= 1'b1;
      else if (m_axis_tready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      fc_q    <= s_axis_tdata[12:0];
      mdw_q   <= s_axis_tdata[38:13];
      mcr_q   <= s_axis_tdata[64:39];
      mono_q  <= s_axis_tdata[65];
      left_q  <= s_axis_tdata[89:66];
      right_q <= s_axis_tdata[113:90];
    end
    if (state_q == bcr_pkg::T_CRV1) begin
      dw_q <= dw_c;
      u2_q <= uu[48:20];
    end
    if (state_q == bcr_pkg::T_CRV2) begin
      steptgt_q <= u4 + bcr_pkg::LVL_W'((bcr_pkg::ONE40 - u4) >> 24);
    end
    if (load_out) begin
      lout_q <= res_l.sample;
      rout_q <= res_r.sample;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {rout_q, lout_q};

endmodule

// File: rtl/bcr_div.sv
// ----------------------------------------------------------------------------
// bcr_div
// Unsigned restoring divider, DIV_STEPS quotient bits per cycle.
// ----------------------------------------------------------------------------
module bcr_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [bcr_pkg::DIV_W-1:0]     dividend_i,
  input  logic [bcr_pkg::DSR_W-1:0]     divisor_i,
  output logic                          done_o,
  output logic [bcr_pkg::DIV_W-1:0]     quo_o,
  output logic [bcr_pkg::DSR_W-1:0]     rem_o
);

  localparam int unsigned ITER  = bcr_pkg::DIV_W / bcr_pkg::DIV_STEPS;
  localparam int unsigned CNT_W = $clog2(ITER + 1);

  logic                          busy_q, done_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [bcr_pkg::DIV_W-1:0]     a_q, a_d;
  logic [bcr_pkg::DSR_W:0]       r_q, r_d;
  logic [bcr_pkg::DSR_W-1:0]     d_q;

  always_comb begin
    a_d = a_q;
    r_d = r_q;
    for (int k = 0; k < bcr_pkg::DIV_STEPS; k++) begin
      r_d = {r_d[bcr_pkg::DSR_W-1:0], a_d[bcr_pkg::DIV_W-1]};
      a_d = {a_d[bcr_pkg::DIV_W-2:0], 1'b0};
      if (r_d >= {1'b0, d_q}) begin
        r_d    = r_d - {1'b0, d_q};
        a_d[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(ITER - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= dividend_i;
      r_q <= '0;
      d_q <= divisor_i;
    end else if (busy_q) begin
      a_q <= a_d;
      r_q <= r_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = a_q;
  assign rem_o  = r_q[bcr_pkg::DSR_W-1:0];

endmodule

// File: rtl/bcr_lane.sv
// ----------------------------------------------------------------------------
// bcr_lane
// One channel: quantize, rescale and mix a sample, or divide a slope.
// ----------------------------------------------------------------------------
module bcr_lane (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bcr_pkg::lane_ctrl_t               ctrl_i,
  input  logic signed [bcr_pkg::SMP_W-1:0]  sample_i,
  input  logic [bcr_pkg::GAIN_W-1:0]        gain_i,
  input  logic [bcr_pkg::GAIN_W-1:0]        recip_i,
  input  logic [bcr_pkg::BASE_W-1:0]        mix_i,
  input  logic signed [bcr_pkg::SLP_W-1:0]  dividend_i,
  input  logic [bcr_pkg::DSR_W-1:0]         divisor_i,
  output bcr_pkg::lane_res_t                res_o
);

  bcr_pkg::lane_state_e state_q, state_d;

  logic                  frame_q, zero_q, done_q;
  logic signed [47:0]    num_q, qs_q;
  logic signed [56:0]    p_q;
  logic signed [40:0]    diff_q;
  logic signed [46:0]    ph_q;
  logic [44:0]           pl_q;
  logic signed [bcr_pkg::SLP_W-1:0] quo_q;
  logic signed [bcr_pkg::SMP_W-1:0] smp_q;

  logic signed [47:0]    prod_x, rem_s, quo_s, t_full;
  logic signed [32:0]    t_v;
  logic signed [56:0]    p_v, wet_full;
  logic signed [40:0]    diff_v;
  logic signed [46:0]    ph_v;
  logic [44:0]           pl_v;
  logic signed [66:0]    acc, accr;
  logic signed [43:0]    mixed;
  logic                  neg, div_start, div_done;
  logic [bcr_pkg::DIV_W-1:0] mag, quo_u;
  logic [bcr_pkg::DSR_W-1:0] rem_u;

  assign neg       = num_q[47];
  assign mag       = neg ? 48'(-num_q) : 48'(num_q);
  assign div_start = (state_q == bcr_pkg::L_LOAD) && !(frame_q && zero_q);

  bcr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag),
    .divisor_i  (divisor_i),
    .done_o     (div_done),
    .quo_o      (quo_u),
    .rem_o      (rem_u)
  );

  always_comb begin
    prod_x   = $signed(sample_i) * $signed({1'b0, gain_i});
    rem_s    = $signed({7'b0, rem_u});
    if (neg) rem_s = -rem_s;
    quo_s    = neg ? -$signed(quo_u) : $signed(quo_u);
    // Negative values get a bias before the arithmetic shift so that it rounds toward zero.
    t_full   = (qs_q + (qs_q[47] ? 48'sd65535 : 48'sd0)) >>> 16;
    t_v      = t_full[32:0];
    p_v      = t_v * $signed({1'b0, recip_i});
    wet_full = (p_q + (p_q[56] ? 57'sd131071 : 57'sd0)) >>> 17;
    diff_v   = wet_full[40:0] - 41'(sample_i);
    ph_v     = $signed(diff_q[40:20]) * $signed({1'b0, mix_i});
    pl_v     = diff_q[19:0] * mix_i;
    acc      = ($signed(67'(ph_q)) <<< 20) + $signed({22'b0, pl_q});
    accr     = (acc + (acc[66] ? 67'sd16777215 : 67'sd0)) >>> 24;
    mixed    = accr[43:0] + 44'(sample_i);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bcr_pkg::L_IDLE: if (ctrl_i.start) state_d = bcr_pkg::L_MUL;
      bcr_pkg::L_MUL:  state_d = bcr_pkg::L_LOAD;
      bcr_pkg::L_LOAD: state_d = (frame_q && zero_q) ? bcr_pkg::L_WET : bcr_pkg::L_DIV;
      bcr_pkg::L_DIV:  if (div_done) state_d = frame_q ? bcr_pkg::L_WET : bcr_pkg::L_IDLE;
      bcr_pkg::L_WET:  state_d = bcr_pkg::L_DIFF;
      bcr_pkg::L_DIFF: state_d = bcr_pkg::L_PROD;
      bcr_pkg::L_PROD: state_d = bcr_pkg::L_SUM;
      bcr_pkg::L_SUM:  state_d = bcr_pkg::L_IDLE;
      default:         state_d = bcr_pkg::L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bcr_pkg::L_IDLE;
      done_q  <= 1'b0;
      frame_q <= 1'b0;
      zero_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= ((state_q == bcr_pkg::L_DIV) && div_done && !frame_q) ||
                 (state_q == bcr_pkg::L_SUM);
      if (state_q == bcr_pkg::L_IDLE && ctrl_i.start) begin
        frame_q <= ctrl_i.frame;
        zero_q  <= ctrl_i.step_zero;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      bcr_pkg::L_MUL: begin
        num_q <= frame_q ? (prod_x <<< 1) : 48'(dividend_i);
      end
      bcr_pkg::L_LOAD: begin
        qs_q <= '0;  // zero step: the wet signal is zero
      end
      bcr_pkg::L_DIV: begin
        if (div_done) begin
          qs_q  <= num_q - rem_s;   // q * step without a multiplier
          quo_q <= quo_s[bcr_pkg::SLP_W-1:0];
        end
      end
      bcr_pkg::L_WET:  p_q    <= p_v;
      bcr_pkg::L_DIFF: diff_q <= diff_v;
      bcr_pkg::L_PROD: begin
        ph_q <= ph_v;
        pl_q <= pl_v;
      end
      bcr_pkg::L_SUM: begin
        if (mixed > 44'sd8388607) begin
          smp_q <= 24'sh7FFFFF;
        end else if (mixed < -44'sd8388608) begin
          smp_q <= 24'sh800000;
        end else begin
          smp_q <= mixed[23:0];
        end
      end
      default: ;
    endcase
  end

  assign res_o.done   = done_q;
  assign res_o.quo    = quo_q;
  assign res_o.sample = smp_q;

endmodule

// File: rtl/bcr_chk.sv
// ----------------------------------------------------------------------------
// bcr_chk
// Port-level checks of the bitcrusher, bound to the top level.
// ----------------------------------------------------------------------------
module bcr_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic s_axis_tuser,
  input logic m_axis_tvalid,
  input logic m_axis_tready
);

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A block-start transaction never produces a result.
  a_blk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == bcr_pkg::OP_BLOCK &&
    !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result from block start");

  // One transaction at a time: busy right after acceptance.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("accepted back to back");

  // Nothing is offered right after reset.
  a_rst: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result after reset");

endmodule

bind bitcrusher_with_param_ramp bcr_chk u_bcr_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

// File: tb/bcr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcr_checker
// Watches the input, output and configuration channels of the bitcrusher,
// predicts each frame's stereo output and compares it with what comes out.
// ----------------------------------------------------------------------------
module bcr_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [bcr_pkg::IN_W-1:0]     s_axis_tdata,
  input  logic                         s_axis_tuser,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [bcr_pkg::OUT_W-1:0]    m_axis_tdata,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_o,
  input  logic [bcr_pkg::CFG_A_W-1:0]  cfg_addr_i,
  input  logic [bcr_pkg::BASE_W-1:0]   cfg_data_i,
  output int                           errors_o,
  output int                           pending_o
);

  localparam longint L_ONE24 = 64'sd1 << 24;
  localparam longint L_ONE40 = 64'sd1 << 40;
  localparam longint QMAX    = 64'sd2147483647;
  localparam longint NMAX    = longint'(bcr_pkg::MAX_BLOCK_DEF);

  longint drywet_reg, crush_reg, gain_reg, recip_reg;
  longint mix_lvl, mix_slp, step_lvl, step_slp;
  logic [bcr_pkg::OUT_W-1:0] expected_out_q[$];

  function automatic longint clip(longint v, longint lo, longint hi);
    clip = v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint crush_sample(longint x);
    longint num, q, t, wet;
    num = 2 * x * gain_reg;
    if (step_lvl == 0) q = num > 0 ? QMAX : (num < 0 ? -QMAX : 0);
    else q = num / step_lvl;
    t   = (q * step_lvl) / 65536;
    wet = (t * recip_reg) / 131072;
    crush_sample = clip(x + ((wet - x) * (mix_lvl / 65536)) / L_ONE24,
                        -8388608, 8388607);
  endfunction

  task automatic predict_item(input logic [bcr_pkg::IN_W-1:0] d, input logic op);
    longint dw, cb, u, u2, u4, v, step_t, mix_t, n, l, r;
    logic [bcr_pkg::SMP_W-1:0] lo, ro;
    if (op == bcr_pkg::OP_BLOCK) begin
      dw = clip(drywet_reg + longint'($signed(d[38:13])), 0, L_ONE24);
      cb = clip(crush_reg + longint'($signed(d[64:39])), 0, L_ONE24);
      u  = L_ONE24 - cb;
      u2 = (u * u) >>> 20;
      u4 = (u2 * u2) >>> 16;
      v  = L_ONE40 - u4;
      step_t = L_ONE40 - v + (v >>> 24);
      mix_t  = dw <<< 16;
      n = longint'(d[12:0]);
      if (n > NMAX) n = NMAX;
      if (n > 0) begin
        mix_slp  = (mix_t - mix_lvl) / n;
        step_slp = (step_t - step_lvl) / n;
      end else begin
        mix_lvl = mix_t;  mix_slp = 0;
        step_lvl = step_t; step_slp = 0;
      end
    end else begin
      l = longint'($signed(d[89:66]));
      r = d[65] ? l : longint'($signed(d[113:90]));
      lo = 24'(crush_sample(l));
      ro = 24'(crush_sample(r));
      expected_out_q.push_back({ro, lo});
      mix_lvl  = clip(mix_lvl + mix_slp, 0, L_ONE40);
      step_lvl = clip(step_lvl + step_slp, 0, L_ONE40);
    end
  endtask

  assign pending_o = expected_out_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    logic [bcr_pkg::OUT_W-1:0] exp_w;
    if (!rst_ni) begin
      drywet_reg = 16777216; crush_reg = 16777216;
      gain_reg = 65536; recip_reg = 65536;
      mix_lvl = 0; mix_slp = 0; step_lvl = 0; step_slp = 0;
      expected_out_q.delete();
      errors_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (bcr_pkg::cfg_reg_e'(cfg_addr_i))
          bcr_pkg::REG_DRYWET: drywet_reg = longint'(cfg_data_i);
          bcr_pkg::REG_CRUSH:  crush_reg  = longint'(cfg_data_i);
          bcr_pkg::REG_GAIN:   gain_reg   = longint'(cfg_data_i[bcr_pkg::GAIN_W-1:0]);
          bcr_pkg::REG_RECIP:  recip_reg  = longint'(cfg_data_i[bcr_pkg::GAIN_W-1:0]);
          default: ;
        endcase
      end
      // compare before predicting: a result never comes in its own cycle
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_out_q.size() == 0) begin
          if (errors_o < 10) $display("ERROR: unexpected output %h", m_axis_tdata);
          errors_o <= errors_o + 1;
        end else begin
          exp_w = expected_out_q.pop_front();
          if (exp_w !== m_axis_tdata) begin
            if (errors_o < 10)
              $display("ERROR: left exp %h got %h, right exp %h got %h",
                       exp_w[23:0], m_axis_tdata[23:0],
                       exp_w[47:24], m_axis_tdata[47:24]);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_item(s_axis_tdata, s_axis_tuser);
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the bitcrusher: directed block and frame
// transactions, then randomized blocks of frames over several register sets.
// ----------------------------------------------------------------------------
module tb;

  localparam int WATCHDOG = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0, s_axis_tready;
  logic [bcr_pkg::IN_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid, m_axis_tready = 1'b0;
  logic [bcr_pkg::OUT_W-1:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0, cfg_ready_o;
  logic [bcr_pkg::CFG_A_W-1:0] cfg_addr_i = '0;
  logic [bcr_pkg::BASE_W-1:0] cfg_data_i = '0;
  int errors, pending;
  bit quiet_phase = 1'b0;   // no idling near the end
  bit hold_done = 1'b0;
  int idle_cycles = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  bitcrusher_with_param_ramp DUT (.*);

  bcr_checker u_checker (.*, .errors_o(errors), .pending_o(pending));

  // Receiver: one long hold-off early on to fill the block, then random stalls.
  initial begin
    int n;
    @(posedge rst_ni);
    m_axis_tready <= 1'b1;
    repeat (300) @(posedge clk_i);
    m_axis_tready <= 1'b0;
    repeat (400) @(posedge clk_i);
    hold_done = 1'b1;
    forever begin
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 10);
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Watchdog: count cycles without any transaction.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else if (rst_ni && hold_done) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Send one item; idle randomly before it.
  task automatic send(input logic op, input logic [12:0] fc, input logic [25:0] mdw,
                      input logic [25:0] mcr, input logic mono,
                      input logic [23:0] l, input logic [23:0] r);
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'b0, r, l, mono, mcr, mdw, fc};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);               // let the checker record the last transaction
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);   // a block start may still be in flight
  endtask

  task automatic write_reg(input bcr_pkg::cfg_reg_e idx,
                           input logic [bcr_pkg::BASE_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [25:0] rnd_mod();
    case ($urandom_range(0, 3))
      0: rnd_mod = 26'(-16777216);
      1: rnd_mod = 26'(16777216);
      2: rnd_mod = 26'($urandom);      // raw bits, any pattern
      default: rnd_mod = 26'(int'($urandom_range(0, 33554432)) - 16777216);
    endcase
  endfunction

  function automatic logic [23:0] rnd_smp();
    case ($urandom_range(0, 5))
      0: rnd_smp = 24'h800000;
      1: rnd_smp = 24'h7FFFFF;
      default: rnd_smp = 24'($urandom);
    endcase
  endfunction

  task automatic frame_rnd();
    send(bcr_pkg::OP_FRAME, 13'($urandom), 26'($urandom), 26'($urandom), 1'($urandom),
         rnd_smp(), rnd_smp());
  endtask

  initial begin
    int sent;
    int fc;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero step before any block start, extremes, mono, snap, long block.
    send(bcr_pkg::OP_FRAME, 13'd0, 26'd0, 26'd0, 1'b0, 24'h7FFFFF, 24'h800000);
    send(bcr_pkg::OP_FRAME, 13'd0, 26'd0, 26'd0, 1'b1, 24'h000000, 24'h123456);
    send(bcr_pkg::OP_FRAME, 13'd0, 26'd0, 26'd0, 1'b0, 24'h800000, 24'h000000);
    send(bcr_pkg::OP_BLOCK, 13'd0, 26'd0, 26'd0, 1'b0, 24'h000000, 24'h000000);
    send(bcr_pkg::OP_FRAME, 13'd0, 26'd0, 26'd0, 1'b0, 24'h7FFFFF, 24'h800000);
    send(bcr_pkg::OP_BLOCK, 13'd0, 26'(-16777216), 26'(16777216), 1'b1,
         24'hFFFFFF, 24'hFFFFFF);
    send(bcr_pkg::OP_FRAME, 13'd0, 26'd0, 26'd0, 1'b1, 24'h400000, 24'h7FFFFF);
    send(bcr_pkg::OP_BLOCK, 13'd3, 26'(16777216), 26'(-16777216), 1'b0,
         24'h000000, 24'h000000);
    repeat (5) send(bcr_pkg::OP_FRAME, 13'h1FFF, 26'h3FFFFFF, 26'h3FFFFFF, 1'b0,
                    rnd_smp(), rnd_smp());
    send(bcr_pkg::OP_BLOCK, 13'h1FFF, 26'h2000000, 26'h1FFFFFF, 1'b0,
         24'h000000, 24'h000000);  // above max
    send(bcr_pkg::OP_FRAME, 13'd0, 26'd0, 26'd0, 1'b0, 24'h7FFFFF, 24'h800000);
    send(bcr_pkg::OP_BLOCK, 13'd4096, 26'(-8000000), 26'd0, 1'b0,
         24'h000000, 24'h000000);
    repeat (3) frame_rnd();
    drain();

    // Random phases over several register sets, extremes included.
    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(bcr_pkg::REG_DRYWET, 25'd0);  write_reg(bcr_pkg::REG_CRUSH, 25'd0);
          write_reg(bcr_pkg::REG_GAIN, 25'd655);  write_reg(bcr_pkg::REG_RECIP, 25'd6553600);
        end
        1: begin
          write_reg(bcr_pkg::REG_DRYWET, 25'd16777216);
          write_reg(bcr_pkg::REG_CRUSH, 25'd16777216);
          write_reg(bcr_pkg::REG_GAIN, 25'd6553600);
          write_reg(bcr_pkg::REG_RECIP, 25'd655);
        end
        default: begin
          write_reg(bcr_pkg::REG_DRYWET, 25'($urandom_range(0, 16777216)));
          write_reg(bcr_pkg::REG_CRUSH, 25'($urandom_range(0, 16777216)));
          write_reg(bcr_pkg::REG_GAIN, 25'($urandom_range(655, 6553600)));
          write_reg(bcr_pkg::REG_RECIP, 25'($urandom_range(655, 6553600)));
        end
      endcase
      if (ph == 7) quiet_phase = 1'b1;
      while (sent < 250 * (ph + 1)) begin
        // mostly short blocks, occasionally long or zero counts
        case ($urandom_range(0, 9))
          0: fc = 0;
          1: fc = $urandom_range(4097, 8191);
          2: fc = $urandom_range(100, 4096);
          default: fc = $urandom_range(1, 40);
        endcase
        send(bcr_pkg::OP_BLOCK, 13'(fc), rnd_mod(), rnd_mod(), 1'($urandom),
             24'($urandom), 24'($urandom));
        sent++;
        repeat ($urandom_range(1, 50)) begin
          frame_rnd();
          sent++;
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
